/* sv/das_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the door actuator sequencer.
// No dependencies; imported by door_actuator_sequencer.
package das_pkg;

  // Fixed field widths of the configuration registers
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int TICK_W     = 16;
  localparam int STEP_W     = 4;
  localparam int FRAME_W    = 9;
  localparam int PULSE_W    = 6;

  // Register reset values
  localparam logic [TICK_W-1:0]  DEBOUNCE_RST    = 16'd10000;
  localparam logic [TICK_W-1:0]  SETTLE_RST      = 16'd20000;
  localparam logic [TICK_W-1:0]  FAULT_STEP_RST  = 16'd20000;
  localparam logic [STEP_W-1:0]  OPEN_STEPS_RST  = 4'd7;
  localparam logic [STEP_W-1:0]  CLOSE_STEPS_RST = 4'd6;
  localparam logic [FRAME_W-1:0] PWM_PERIOD_RST  = 9'd360;
  localparam logic [PULSE_W-1:0] OPEN_WIDTH_RST  = 6'd31;
  localparam logic [PULSE_W-1:0] CLOSE_WIDTH_RST = 6'd21;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE    = 3'd0,
    CFG_SETTLE      = 3'd1,
    CFG_FAULT_STEP  = 3'd2,
    CFG_OPEN_STEPS  = 3'd3,
    CFG_CLOSE_STEPS = 3'd4,
    CFG_PWM_PERIOD  = 3'd5,
    CFG_OPEN_WIDTH  = 3'd6,
    CFG_CLOSE_WIDTH = 3'd7
  } cfg_idx_t;

  // Sequencer phases, one-hot
  typedef enum logic [11:0] {
    PH_TOP         = 12'b0000_0000_0001,
    PH_W_MAN       = 12'b0000_0000_0010,
    PH_W_AUTO      = 12'b0000_0000_0100,
    PH_W_OPEN_BTN  = 12'b0000_0000_1000,
    PH_W_CLOSE_BTN = 12'b0000_0001_0000,
    PH_W_AFTER     = 12'b0000_0010_0000,
    PH_OPEN_RELAY  = 12'b0000_0100_0000,
    PH_OPEN_RUN    = 12'b0000_1000_0000,
    PH_CLOSE_RELAY = 12'b0001_0000_0000,
    PH_CLOSE_RUN   = 12'b0010_0000_0000,
    PH_SLEEP       = 12'b0100_0000_0000,
    PH_HALT        = 12'b1000_0000_0000
  } phase_t;

  // One tick item: sampled switch and light levels
  typedef struct packed {
    logic auto_mode;
    logic open_button_n;
    logic close_button_n;
    logic door_up;
    logic door_down;
    logic light_high;
    logic light_wake;
  } in_t;

  // One result item: actuator and status levels
  typedef struct packed {
    logic servo_out;
    logic relay_on;
    logic led_on;
    logic asleep;
    logic fault_halt;
  } out_t;

endpackage

/* sv/door_actuator_sequencer.sv */
`timescale 1ns / 1ps
// Door actuator sequencer: tick-driven door controller with servo PWM and relay.
// Depends on das_pkg (payload structs, phase and register index codes).
//
// Usage:
//   in_*   : one transfer per timer tick carrying the sampled switch and light
//            levels (in_t). Each tick yields exactly one result transfer.
//   out_*  : servo pulse, relay, LED, asleep and halt levels (out_t).
//   cfg_*  : register writes (index, data); always ready. Write only while
//            the block holds no tick whose result is still undelivered.
// Order: a tick is captured in the input register; once the result slot is
//   free, the sequencer updates its state and the result register takes the
//   result on the same edge, so a tick passes the input and result registers in turn.
// Throughput: one tick per clock while out_ready is high; the input register
//   and the result register let a new tick in while a finished result still waits.
// Stall: when out_ready is low, the result register holds, the pending tick
//   stays in the input register and in_ready drops until the result is taken.
// Reset (rst_n low, synchronous): registers return to their defaults, the
//   sequencer goes to the top of its loop, LED on, servo and relay off.
module door_actuator_sequencer
  import das_pkg::*;
#(
  parameter int WAIT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_t                  out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int EXT_W = ((WAIT_BITS > TICK_W) ? WAIT_BITS : TICK_W) + 1;

  // Configuration registers
  logic [TICK_W-1:0]  debounce_r, settle_r, fault_step_r;
  logic [STEP_W-1:0]  open_steps_r, close_steps_r;
  logic [FRAME_W-1:0] pwm_period_r;
  logic [PULSE_W-1:0] open_width_r, close_width_r;

  // Handshake registers
  logic in_valid_r, out_valid_r;
  in_t  in_data_r;
  out_t out_data_r, out_data_nxt;
  logic fire;

  // Sequencer state
  phase_t               phase_r, phase_nxt;
  logic                 ret_sleep_r, ret_sleep_nxt;
  logic [WAIT_BITS-1:0] wait_r, wait_nxt;
  logic [STEP_W-1:0]    steps_r, steps_nxt;
  logic [FRAME_W-1:0]   frame_r, frame_nxt;
  logic [PULSE_W-1:0]   pulse_r, pulse_nxt;
  logic                 armed_r, armed_nxt;
  logic                 servo_en_r, servo_en_nxt;
  logic [PULSE_W-1:0]   width_r, width_nxt;
  logic                 servo_r, servo_nxt;
  logic                 relay_r, relay_nxt;
  logic                 led_r, led_nxt;
  logic                 wake_last_r, wake_last_nxt;
  logic                 halted_r, halted_nxt;

  // Wait targets: d+1 for debounce and settle, d for the fault step, wrapped to the wait counter width
  logic [EXT_W-1:0]     debounce_ext, settle_ext, fault_ext;
  logic [WAIT_BITS-1:0] debounce_tgt, settle_tgt, fault_tgt;

  assign debounce_ext = EXT_W'(debounce_r) + EXT_W'(1);
  assign settle_ext   = EXT_W'(settle_r) + EXT_W'(1);
  assign fault_ext    = EXT_W'(fault_step_r);
  assign debounce_tgt = debounce_ext[WAIT_BITS-1:0];
  assign settle_tgt   = settle_ext[WAIT_BITS-1:0];
  assign fault_tgt    = fault_ext[WAIT_BITS-1:0];

  // Handshake: the sequencer steps when a tick is held and the result slot frees
  assign fire      = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || fire;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r    <= DEBOUNCE_RST;
      settle_r      <= SETTLE_RST;
      fault_step_r  <= FAULT_STEP_RST;
      open_steps_r  <= OPEN_STEPS_RST;
      close_steps_r <= CLOSE_STEPS_RST;
      pwm_period_r  <= PWM_PERIOD_RST;
      open_width_r  <= OPEN_WIDTH_RST;
      close_width_r <= CLOSE_WIDTH_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_DEBOUNCE:    debounce_r    <= cfg_data;
        CFG_SETTLE:      settle_r      <= cfg_data;
        CFG_FAULT_STEP:  fault_step_r  <= cfg_data;
        CFG_OPEN_STEPS:  open_steps_r  <= cfg_data[STEP_W-1:0];
        CFG_CLOSE_STEPS: close_steps_r <= cfg_data[STEP_W-1:0];
        CFG_PWM_PERIOD:  pwm_period_r  <= cfg_data[FRAME_W-1:0];
        CFG_OPEN_WIDTH:  open_width_r  <= cfg_data[PULSE_W-1:0];
        CFG_CLOSE_WIDTH: close_width_r <= cfg_data[PULSE_W-1:0];
        default: ;
      endcase
    end
  end

  // Next-state logic for one tick
  always_comb begin
    logic                 wake_edge;
    logic [FRAME_W-1:0]   frame_inc;
    logic [WAIT_BITS-1:0] wait_inc;
    logic [STEP_W-1:0]    steps_inc;
    logic                 opening;
    logic                 limit;
    phase_t               top_phase;

    phase_nxt     = phase_r;
    ret_sleep_nxt = ret_sleep_r;
    wait_nxt      = wait_r;
    steps_nxt     = steps_r;
    frame_nxt     = frame_r;
    pulse_nxt     = pulse_r;
    armed_nxt     = armed_r;
    servo_en_nxt  = servo_en_r;
    width_nxt     = width_r;
    servo_nxt     = servo_r;
    relay_nxt     = relay_r;
    led_nxt       = led_r;
    halted_nxt    = halted_r;

    wake_edge     = wake_last_r && !in_data_r.light_wake;
    wake_last_nxt = in_data_r.light_wake;
    frame_inc     = frame_r + FRAME_W'(1);
    wait_inc      = wait_r + WAIT_BITS'(1);
    steps_inc     = steps_r + STEP_W'(1);
    top_phase     = in_data_r.auto_mode ? PH_W_AUTO : PH_W_MAN;
    opening       = (phase_r == PH_OPEN_RELAY) || (phase_r == PH_OPEN_RUN) ||
                    (phase_r == PH_W_OPEN_BTN) ||
                    ((phase_r == PH_W_AUTO) && !(in_data_r.door_up));
    limit         = 1'b0;

    if (phase_r == PH_HALT) begin
      // frozen until reset
    end else if (phase_r == PH_SLEEP) begin
      if (wake_edge) begin
        phase_nxt = PH_W_AFTER;
        wait_nxt  = '0;
      end
    end else begin
      // Servo pulse generator
      if (servo_en_r) begin
        if (frame_inc == pwm_period_r) begin
          frame_nxt = '0;
          pulse_nxt = '0;
          armed_nxt = 1'b1;
        end else begin
          frame_nxt = frame_inc;
          if (armed_r) begin
            if (pulse_r == width_r) begin
              armed_nxt = 1'b0;
              servo_nxt = 1'b0;
            end else begin
              servo_nxt = 1'b1;
              pulse_nxt = pulse_r + PULSE_W'(1);
            end
          end
        end
      end
      wait_nxt = wait_inc;
      led_nxt  = !led_r;

      case (phase_r)
        PH_W_MAN: begin
          if (wait_inc == settle_tgt) begin
            wait_nxt = '0;
            if (in_data_r.auto_mode) begin
              phase_nxt = PH_W_AUTO;
            end else if (!in_data_r.open_button_n) begin
              phase_nxt = PH_W_OPEN_BTN;
            end else if (!in_data_r.close_button_n) begin
              phase_nxt = PH_W_CLOSE_BTN;
            end else begin
              phase_nxt = PH_W_MAN;
            end
          end
        end
        PH_W_AUTO: begin
          if (wait_inc == settle_tgt) begin
            if (!in_data_r.auto_mode) begin
              phase_nxt = PH_W_MAN;
              wait_nxt  = '0;
            end else begin
              // Decide whether a move is due; the door direction follows light
              if (in_data_r.door_up) begin
                limit = in_data_r.light_high || in_data_r.light_wake;
              end else if (in_data_r.door_down) begin
                limit = !in_data_r.light_high;
              end else begin
                limit = !in_data_r.light_high;
              end
              if (limit) begin
                phase_nxt = PH_SLEEP;
                led_nxt   = 1'b0;
              end else begin
                // Start a move that returns to sleep; skipped if the target limit is closed
                ret_sleep_nxt = 1'b1;
                if (opening ? in_data_r.door_up : in_data_r.door_down) begin
                  phase_nxt = PH_SLEEP;
                  led_nxt   = 1'b0;
                end else begin
                  relay_nxt = 1'b1;
                  wait_nxt  = '0;
                  phase_nxt = opening ? PH_OPEN_RELAY : PH_CLOSE_RELAY;
                end
              end
            end
          end
        end
        PH_W_OPEN_BTN, PH_W_CLOSE_BTN: begin
          if (wait_inc == debounce_tgt) begin
            wait_nxt  = '0;
            phase_nxt = PH_W_AFTER;
            if (opening ? !in_data_r.open_button_n : !in_data_r.close_button_n) begin
              ret_sleep_nxt = 1'b0;
              limit         = opening ? in_data_r.door_up : in_data_r.door_down;
              if (!limit) begin
                relay_nxt = 1'b1;
                phase_nxt = opening ? PH_OPEN_RELAY : PH_CLOSE_RELAY;
              end
            end
          end
        end
        PH_W_AFTER: begin
          if (wait_inc == settle_tgt) begin
            phase_nxt = top_phase;
            wait_nxt  = '0;
          end
        end
        PH_OPEN_RELAY, PH_CLOSE_RELAY, PH_OPEN_RUN, PH_CLOSE_RUN: begin
          limit = opening ? in_data_r.door_up : in_data_r.door_down;
          if ((phase_r == PH_OPEN_RELAY) || (phase_r == PH_CLOSE_RELAY)) begin
            // Relay settled: begin driving the servo
            if (wait_inc == debounce_tgt) begin
              width_nxt    = opening ? open_width_r : close_width_r;
              servo_en_nxt = 1'b1;
              wait_nxt     = '0;
              steps_nxt    = '0;
              phase_nxt    = opening ? PH_OPEN_RUN : PH_CLOSE_RUN;
            end
          end else if (!limit && (wait_inc == fault_tgt)) begin
            wait_nxt  = '0;
            steps_nxt = steps_inc;
          end
          if ((phase_nxt == PH_OPEN_RUN) || (phase_nxt == PH_CLOSE_RUN)) begin
            if (limit) begin
              // Normal stop at the limit switch
              width_nxt    = '0;
              servo_en_nxt = 1'b0;
              relay_nxt    = 1'b0;
              if (ret_sleep_r) begin
                phase_nxt = PH_SLEEP;
                led_nxt   = 1'b0;
              end else begin
                phase_nxt = PH_W_AFTER;
                wait_nxt  = '0;
              end
            end else if ((steps_nxt >= (opening ? open_steps_r : close_steps_r)) &&
                         ((steps_nxt != steps_r) || (phase_r != phase_nxt))) begin
              // Timeout: halt, except a close move in automatic mode just stops
              if (opening || !in_data_r.auto_mode) begin
                servo_en_nxt = 1'b0;
                servo_nxt    = 1'b0;
                relay_nxt    = 1'b0;
                led_nxt      = 1'b0;
                halted_nxt   = 1'b1;
                phase_nxt    = PH_HALT;
              end else begin
                width_nxt    = '0;
                servo_en_nxt = 1'b0;
                relay_nxt    = 1'b0;
                if (ret_sleep_r) begin
                  phase_nxt = PH_SLEEP;
                  led_nxt   = 1'b0;
                end else begin
                  phase_nxt = PH_W_AFTER;
                  wait_nxt  = '0;
                end
              end
            end
          end
        end
        default: begin
          phase_nxt = top_phase;
          wait_nxt  = '0;
        end
      endcase
    end

    out_data_nxt.servo_out  = servo_nxt;
    out_data_nxt.relay_on   = relay_nxt;
    out_data_nxt.led_on     = led_nxt;
    out_data_nxt.asleep     = (phase_nxt == PH_SLEEP);
    out_data_nxt.fault_halt = halted_nxt;
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  // Sequencer state update, one step per tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_TOP;
      ret_sleep_r <= 1'b0;
      wait_r      <= '0;
      steps_r     <= '0;
      frame_r     <= '0;
      pulse_r     <= '0;
      armed_r     <= 1'b1;
      servo_en_r  <= 1'b0;
      width_r     <= '0;
      servo_r     <= 1'b0;
      relay_r     <= 1'b0;
      led_r       <= 1'b1;
      wake_last_r <= 1'b0;
      halted_r    <= 1'b0;
    end else if (fire) begin
      phase_r     <= phase_nxt;
      ret_sleep_r <= ret_sleep_nxt;
      wait_r      <= wait_nxt;
      steps_r     <= steps_nxt;
      frame_r     <= frame_nxt;
      pulse_r     <= pulse_nxt;
      armed_r     <= armed_nxt;
      servo_en_r  <= servo_en_nxt;
      width_r     <= width_nxt;
      servo_r     <= servo_nxt;
      relay_r     <= relay_nxt;
      led_r       <= led_nxt;
      wake_last_r <= wake_last_nxt;
      halted_r    <= halted_nxt;
    end
  end

  // Halt is final and leaves the actuators unpowered
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |=> halted_r)
    else $error("halt flag cleared without reset");

  a_halt_safe: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |-> (!relay_r && !servo_en_r && !servo_r))
    else $error("actuator active while halted");

  // Sleeping never happens with a move in progress
  a_sleep_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_SLEEP) |-> (!relay_r && !servo_en_r))
    else $error("relay or servo on while asleep");

endmodule
